@@ design/mllk_pkg.sv @@
// ----------------------------------------------------------------------------
// mllk_pkg
// Shared types, constants and constant tables for the multinomial logit
// log-likelihood accumulator.
// ----------------------------------------------------------------------------
package mllk_pkg;

    // Feature count and queue depth
    localparam int MAX_FEATURES     = 6;
    localparam int NUM_FEATURES_DEF = 6;
    localparam int QUEUE_DEPTH      = 2;

    // Configuration register indexes
    localparam logic [2:0] CFG_IDX_SIGN  = 3'd6;
    localparam logic [2:0] CFG_IDX_LAST  = 3'd5;

    // Sign restriction codes
    localparam logic [1:0] SGN_FREE = 2'd0;
    localparam logic [1:0] SGN_POS  = 2'd1;
    localparam logic [1:0] SGN_NEG  = 2'd2;

    // Fixed-point constants
    localparam logic [30:0] LOG2E_Q30 = 31'h5C551D95;
    localparam logic [29:0] LN2_Q30   = 30'h2C5C85FE;

    // Input row
    typedef struct packed {
        logic signed [31:0] feat_0;
        logic signed [31:0] feat_1;
        logic signed [31:0] feat_2;
        logic signed [31:0] feat_3;
        logic signed [31:0] feat_4;
        logic signed [31:0] feat_5;
        logic               is_chosen;
        logic               set_end;
        logic               data_start;
    } t_in_item;

    // Result of one choice set
    typedef struct packed {
        logic signed [31:0] occasion_term;
        logic signed [47:0] running_total;
        logic               saturated;
    } t_out_item;

    // Request to the exponential unit
    typedef struct packed {
        logic               start;
        logic               wide;
        logic signed [31:0] x;
    } t_exp_req;

    // Response from the exponential unit
    typedef struct packed {
        logic        done;
        logic        sat;
        logic [47:0] val;
    } t_exp_rsp;

    // Coefficient state seen by the datapath
    typedef struct packed {
        logic             busy;
        logic             coef_sat;
        logic [5:0][31:0] eff;
    } t_cfg_state;

    typedef logic [30:0] t_pow_tab [16];

    // Integer square root, used only to build the constant table
    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (b > v) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Table of 2^(2^-(j+1)) in Q30 by repeated square roots
    function automatic t_pow_tab f_build_tab();
        t_pow_tab    t;
        logic [63:0] w;
        w = f_isqrt(64'd2 << 60);
        t[0] = w[30:0];
        for (int j = 1; j < 16; j++) begin
            w = f_isqrt({2'b0, w[30:0], 31'b0} >> 1);
            t[j] = w[30:0];
        end
        return t;
    endfunction

    localparam t_pow_tab POW_TAB = f_build_tab();

endpackage

@@ design/mllk_exp.sv @@
// ----------------------------------------------------------------------------
// mllk_exp
// Iterative fixed-point exponential: Q16.16 in, unsigned Q16 out, with
// saturation at a 31-bit or a 48-bit limit.
// ----------------------------------------------------------------------------
module mllk_exp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mllk_pkg::t_exp_req    i_req,
    output mllk_pkg::t_exp_rsp    o_rsp
);
    import mllk_pkg::*;

    localparam logic [1:0] E_IDLE  = 2'd0;
    localparam logic [1:0] E_MUL   = 2'd1;
    localparam logic [1:0] E_STEP  = 2'd2;
    localparam logic [1:0] E_SHIFT = 2'd3;

    logic [1:0]         r_state;
    logic signed [31:0] r_x;
    logic               r_wide;
    logic signed [17:0] r_k;
    logic [15:0]        r_f;
    logic [3:0]         r_j;
    logic [31:0]        r_acc;
    logic               r_done;
    logic               r_sat;
    logic [47:0]        r_val;

    logic signed [63:0] y;
    logic [63:0]        pr;
    logic [63:0]        pr_rnd;
    logic signed [18:0] sh;
    logic signed [18:0] sneg;
    logic [49:0]        lim;
    logic [49:0]        v;
    logic [63:0]        rnd;
    logic [63:0]        vneg;
    logic               n_sat;
    logic [49:0]        n_val;

    // Scale by log2(e) and one table step
    assign y      = $signed(r_x) * $signed({1'b0, LOG2E_Q30});
    assign pr     = r_acc * POW_TAB[r_j];
    assign pr_rnd = pr + 64'h2000_0000;

    // Final shift by the integer part, with rounding and saturation
    always_comb begin
        sh    = {r_k[17], r_k} - 19'sd14;
        sneg  = -sh;
        lim   = r_wide ? {2'b0, 48'hFFFF_FFFF_FFFF} : 50'h7FFF_FFFF;
        rnd   = 64'd1 << (sneg[5:0] - 6'd1);
        vneg  = ({32'b0, r_acc} + rnd) >> sneg[5:0];
        v     = '0;
        n_sat = 1'b0;
        if (!sh[18]) begin
            if (sh > 19'sd17) begin
                n_sat = 1'b1;
            end else begin
                v = {18'b0, r_acc} << sh[4:0];
            end
        end else if (sneg <= 19'sd32) begin
            v = vneg[49:0];
        end
        if (n_sat || v > lim) begin
            n_sat = 1'b1;
            n_val = lim;
        end else begin
            n_val = v;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == E_SHIFT);
            case (r_state)
                E_IDLE: begin
                    if (i_req.start) begin
                        r_x     <= i_req.x;
                        r_wide  <= i_req.wide;
                        r_state <= E_MUL;
                    end
                end
                E_MUL: begin
                    r_k     <= y[63:46];
                    r_f     <= y[45:30];
                    r_j     <= '0;
                    r_acc   <= 32'h4000_0000;
                    r_state <= E_STEP;
                end
                E_STEP: begin
                    if (r_f[15]) r_acc <= pr_rnd[61:30];
                    r_f <= {r_f[14:0], 1'b0};
                    r_j <= r_j + 4'd1;
                    if (r_j == 4'd15) r_state <= E_SHIFT;
                end
                E_SHIFT: begin
                    r_val   <= n_val[47:0];
                    r_sat   <= n_sat;
                    r_state <= E_IDLE;
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.val  = r_val;

endmodule

@@ design/mllk_front.sv @@
// ----------------------------------------------------------------------------
// mllk_front
// Front end: accepts rows and holds them in a short queue for the datapath.
// ----------------------------------------------------------------------------
module mllk_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mllk_pkg::t_in_item    i_in_data,
    input  logic                  i_pop,
    output logic                  o_head_valid,
    output mllk_pkg::t_in_item    o_head
);
    import mllk_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_in_item      r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;
    logic          push;
    logic          pop;

    assign o_in_stall   = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign push         = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_cnt != '0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rd];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_in_data;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= (r_wr == PW'(QUEUE_DEPTH-1)) ? '0 : r_wr + 1'b1;
            if (pop)  r_rd <= (r_rd == PW'(QUEUE_DEPTH-1)) ? '0 : r_rd + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

@@ design/mllk_cfg.sv @@
// ----------------------------------------------------------------------------
// mllk_cfg
// Configuration registers and recomputation of the effective coefficients
// after each write to a coefficient or to the sign register.
// ----------------------------------------------------------------------------
module mllk_cfg #(
    parameter int NUM_FEATURES = mllk_pkg::NUM_FEATURES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output mllk_pkg::t_cfg_state  o_state
);
    import mllk_pkg::*;

    logic [31:0]      r_raw [MAX_FEATURES];
    logic [11:0]      r_sign;
    logic [5:0][31:0] r_eff;
    logic             r_busy;
    logic             r_wait;
    logic [2:0]       r_i;
    logic             r_sat_acc;
    logic             r_coef_sat;

    t_exp_req         req;
    t_exp_rsp         rsp;
    logic [1:0]       mode;
    logic             wr;
    logic             n_sat_acc;
    logic             step_done;

    mllk_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    assign o_cfg_ready = !r_busy;
    assign wr          = i_cfg_valid && !r_busy;
    assign mode        = r_sign[{r_i, 1'b0} +: 2];

    // Exp requests and completion of one coefficient
    always_comb begin
        req.start = r_busy && !r_wait && (mode == SGN_POS || mode == SGN_NEG);
        req.wide  = 1'b0;
        req.x     = $signed(r_raw[r_i]);
        step_done = r_busy && (r_wait ? rsp.done : !req.start);
        n_sat_acc = r_sat_acc;
        if (r_wait && rsp.done && rsp.sat && (32'(r_i) < NUM_FEATURES)) n_sat_acc = 1'b1;
    end

    // Register writes and the recompute sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_wait     <= 1'b0;
            r_i        <= '0;
            r_sat_acc  <= 1'b0;
            r_coef_sat <= 1'b0;
            r_sign     <= '0;
            r_eff      <= '0;
            for (int i = 0; i < MAX_FEATURES; i++) r_raw[i] <= '0;
        end else begin
            if (wr && i_cfg_index <= CFG_IDX_SIGN) begin
                if (i_cfg_index == CFG_IDX_SIGN) r_sign <= i_cfg_data[11:0];
                else                             r_raw[i_cfg_index] <= i_cfg_data;
                r_busy    <= 1'b1;
                r_wait    <= 1'b0;
                r_i       <= '0;
                r_sat_acc <= 1'b0;
            end else if (r_busy) begin
                if (req.start) r_wait <= 1'b1;
                r_sat_acc <= n_sat_acc;
                if (step_done) begin
                    r_wait <= 1'b0;
                    if (r_wait) begin
                        r_eff[r_i] <= (mode == SGN_POS) ? rsp.val[31:0] : -rsp.val[31:0];
                    end else begin
                        r_eff[r_i] <= r_raw[r_i];
                    end
                    if (r_i == CFG_IDX_LAST) begin
                        r_busy     <= 1'b0;
                        r_coef_sat <= n_sat_acc;
                    end else begin
                        r_i <= r_i + 3'd1;
                    end
                end
            end
        end
    end

    assign o_state.busy     = r_busy;
    assign o_state.coef_sat = r_coef_sat;
    assign o_state.eff      = r_eff;

endmodule

@@ design/mllk_back.sv @@
// ----------------------------------------------------------------------------
// mllk_back
// Back end: utility dot product, exp into the set denominator, and at the
// end of a set the log of the denominator, the term and the running total.
// ----------------------------------------------------------------------------
module mllk_back #(
    parameter int NUM_FEATURES = mllk_pkg::NUM_FEATURES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_head_valid,
    input  mllk_pkg::t_in_item    i_head,
    output logic                  o_pop,
    input  mllk_pkg::t_cfg_state  i_cfg,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mllk_pkg::t_out_item   o_out_data
);
    import mllk_pkg::*;

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_MUL   = 4'd1;
    localparam logic [3:0] B_ADD   = 4'd2;
    localparam logic [3:0] B_UTIL  = 4'd3;
    localparam logic [3:0] B_EXPGO = 4'd4;
    localparam logic [3:0] B_EXP   = 4'd5;
    localparam logic [3:0] B_NORM  = 4'd6;
    localparam logic [3:0] B_SQR   = 4'd7;
    localparam logic [3:0] B_LNMUL = 4'd8;
    localparam logic [3:0] B_TERM  = 4'd9;
    localparam logic [3:0] B_TOT   = 4'd10;
    localparam logic [3:0] B_OUT   = 4'd11;

    localparam logic [2:0] LAST_F = 3'(NUM_FEATURES - 1);

    logic [3:0]         r_state;
    t_in_item           r_item;
    logic [2:0]         r_fi;
    logic signed [63:0] r_prod;
    logic signed [66:0] r_dot;
    logic signed [31:0] r_util;
    logic [47:0]        r_denom;
    logic signed [31:0] r_chosen;
    logic signed [47:0] r_total;
    logic               r_sat;
    logic [47:0]        r_nd;
    logic [5:0]         r_p;
    logic [30:0]        r_m;
    logic [15:0]        r_frac;
    logic [3:0]         r_sq;
    logic signed [52:0] r_lnprod;
    logic signed [31:0] r_term;
    logic               r_out_valid;
    t_out_item          r_out;

    t_exp_req           req;
    t_exp_rsp           rsp;
    logic signed [31:0] feat;
    logic signed [50:0] dsh;
    logic [48:0]        den_sum;
    logic [47:0]        n_denom;
    logic [61:0]        sq;
    logic [31:0]        sq_t;
    logic signed [6:0]  pm;
    logic signed [21:0] l2;
    logic signed [52:0] lnr;
    logic signed [22:0] ln;
    logic signed [32:0] diff;
    logic signed [48:0] tot;
    logic               out_free;

    mllk_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    assign req.start = (r_state == B_EXPGO);
    assign req.wide  = 1'b1;
    assign req.x     = r_util;

    assign o_pop    = (r_state == B_IDLE) && i_head_valid && !i_cfg.busy;
    assign out_free = !r_out_valid || !i_out_stall;

    // Feature select for the shared multiplier
    always_comb begin
        case (r_fi)
            3'd0:    feat = r_item.feat_0;
            3'd1:    feat = r_item.feat_1;
            3'd2:    feat = r_item.feat_2;
            3'd3:    feat = r_item.feat_3;
            3'd4:    feat = r_item.feat_4;
            3'd5:    feat = r_item.feat_5;
            default: feat = '0;
        endcase
    end

    // Denominator, log and total arithmetic
    always_comb begin
        dsh     = r_dot[66:16];
        den_sum = {1'b0, r_denom} + {1'b0, rsp.val};
        n_denom = den_sum[48] ? 48'hFFFF_FFFF_FFFF : den_sum[47:0];
        sq      = r_m * r_m;
        sq_t    = sq[61:30];
        pm      = $signed({1'b0, r_p}) - 7'sd16;
        l2      = $signed({pm[5:0], r_frac});
        lnr     = r_lnprod + 53'sh2000_0000;
        ln      = lnr[52:30];
        diff    = 33'(r_chosen) - 33'(ln);
        tot     = 49'(r_total) + 49'(r_term);
    end

    // Row and set sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_denom     <= '0;
            r_chosen    <= '0;
            r_total     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != B_OUT) r_out_valid <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_item <= i_head;
                        if (i_head.data_start) begin
                            r_total  <= '0;
                            r_sat    <= 1'b0;
                            r_denom  <= '0;
                            r_chosen <= '0;
                        end
                        r_fi    <= '0;
                        r_dot   <= '0;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_prod  <= $signed(i_cfg.eff[r_fi]) * feat;
                    r_state <= B_ADD;
                end
                B_ADD: begin
                    r_dot <= r_dot + 67'(r_prod);
                    if (r_fi == LAST_F) begin
                        r_state <= B_UTIL;
                    end else begin
                        r_fi    <= r_fi + 3'd1;
                        r_state <= B_MUL;
                    end
                end
                B_UTIL: begin
                    if (dsh > 51'sd2147483647) begin
                        r_util <= 32'sh7FFF_FFFF;
                        r_sat  <= 1'b1;
                    end else if (dsh < -51'sd2147483648) begin
                        r_util <= 32'sh8000_0000;
                        r_sat  <= 1'b1;
                    end else begin
                        r_util <= dsh[31:0];
                    end
                    r_state <= B_EXPGO;
                end
                B_EXPGO: begin
                    r_state <= B_EXP;
                end
                B_EXP: begin
                    if (rsp.done) begin
                        r_denom <= n_denom;
                        if (den_sum[48] || rsp.sat) r_sat <= 1'b1;
                        if (r_item.is_chosen) r_chosen <= r_util;
                        if (r_item.set_end) begin
                            r_nd    <= (n_denom == '0) ? 48'd1 : n_denom;
                            r_p     <= 6'd47;
                            r_state <= B_NORM;
                        end else begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                B_NORM: begin
                    if (r_nd[47]) begin
                        r_m     <= r_nd[47:17];
                        r_frac  <= '0;
                        r_sq    <= '0;
                        r_state <= B_SQR;
                    end else begin
                        r_nd <= {r_nd[46:0], 1'b0};
                        r_p  <= r_p - 6'd1;
                    end
                end
                B_SQR: begin
                    if (sq_t[31]) begin
                        r_m    <= sq_t[31:1];
                        r_frac <= {r_frac[14:0], 1'b1};
                    end else begin
                        r_m    <= sq_t[30:0];
                        r_frac <= {r_frac[14:0], 1'b0};
                    end
                    r_sq <= r_sq + 4'd1;
                    if (r_sq == 4'd15) r_state <= B_LNMUL;
                end
                B_LNMUL: begin
                    r_lnprod <= l2 * $signed({1'b0, LN2_Q30});
                    r_state  <= B_TERM;
                end
                B_TERM: begin
                    if (diff > 33'sd2147483647) begin
                        r_term <= 32'sh7FFF_FFFF;
                        r_sat  <= 1'b1;
                    end else if (diff < -33'sd2147483648) begin
                        r_term <= 32'sh8000_0000;
                        r_sat  <= 1'b1;
                    end else begin
                        r_term <= diff[31:0];
                    end
                    r_state <= B_TOT;
                end
                B_TOT: begin
                    if (tot > 49'sh0_7FFF_FFFF_FFFF) begin
                        r_total <= 48'sh7FFF_FFFF_FFFF;
                        r_sat   <= 1'b1;
                    end else if (tot < -49'sh0_8000_0000_0000) begin
                        r_total <= 48'sh8000_0000_0000;
                        r_sat   <= 1'b1;
                    end else begin
                        r_total <= tot[47:0];
                    end
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (out_free) begin
                        r_out.occasion_term <= r_term;
                        r_out.running_total <= r_total;
                        r_out.saturated     <= r_sat || i_cfg.coef_sat;
                        r_out_valid         <= 1'b1;
                        r_denom             <= '0;
                        r_chosen            <= '0;
                        r_state             <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/mnl_log_likelihood_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// mnl_log_likelihood_accumulator_top
// Multinomial logit log-likelihood accumulator over ragged choice sets.
//
//   Channel   Direction  Handshake            Payload
//   in        input      valid / stall        t_in_item, one alternative row
//   out       output     valid / stall        t_out_item, one per set end
//   cfg       input      valid / ready        3-bit index, 32-bit data
//
// In the back end a row goes through the shared multiplier, one feature at a
// time, and then through the bit-serial exponential unit. A set-ending row
// adds a leading-one search, the log squaring and the term and total steps.
// After a configuration write the coefficients are recomputed one at a time;
// cfg ready is low and rows wait in the queue meanwhile.
// Reset is synchronous and clears all accumulators and coefficients.
// Rows queue while the back end works; a stalled result holds in its register.
// ----------------------------------------------------------------------------
module mnl_log_likelihood_accumulator_top #(
    parameter int NUM_FEATURES = mllk_pkg::NUM_FEATURES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mllk_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mllk_pkg::t_out_item   o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    import mllk_pkg::*;

    logic       head_valid;
    t_in_item   head;
    logic       pop;
    t_cfg_state cfg_state;

    // Row queue
    mllk_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Coefficient registers
    mllk_cfg #(.NUM_FEATURES(NUM_FEATURES)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_state     (cfg_state)
    );

    // Likelihood datapath
    mllk_back #(.NUM_FEATURES(NUM_FEATURES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_cfg        (cfg_state),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

@@ verif/tb_mnl_log_likelihood_accumulator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multinomial logit log-likelihood accumulator testbench
// Streams ragged choice sets through the accumulator under several coefficient
// and sign-restriction settings, with random idling on both channels. A
// fixed-point predictor works out every set result, and a scoreboard compares
// each result transaction with it field by field.
// ----------------------------------------------------------------------------
module tb_mnl_log_likelihood_accumulator_top;
    import mllk_pkg::*;

    localparam logic [2:0] CFG_IDX_UNUSED = 3'd7;
    localparam logic [1:0] SGN_SPARE      = 2'd3;
    localparam longint     LOG2E    = 64'd1549082005;
    localparam longint     LN2      = 64'd744261118;
    localparam longint     MAX32    = 64'sd2147483647;
    localparam longint     MIN32    = -64'sd2147483648;
    localparam longint     MAX48    = 64'sd140737488355327;
    localparam longint     MIN48    = -64'sd140737488355328;
    localparam longint unsigned UMAX48 = 64'd281474976710655;

    // Scoreboard holding a private copy of the accumulator state
    class likelihood_scoreboard;
        longint unsigned pow2_frac [16];
        longint          raw_coef [6];
        longint          eff_coef [6];
        bit [11:0]       sign_mode;
        longint unsigned denom;
        longint          chosen_util;
        longint          total;
        bit              sat_seen;
        bit              coef_ovf;
        t_out_item       expected_sets [$];
        int              errors;
        int              sets_checked;

        function new();
            longint unsigned w;
            w = root(64'd2 << 60);
            pow2_frac[0] = w;
            for (int j = 1; j < 16; j++) begin
                pow2_frac[j] = root(pow2_frac[j - 1] << 30);
            end
            for (int i = 0; i < 6; i++) begin
                raw_coef[i] = 0;
                eff_coef[i] = 0;
            end
            sign_mode = '0;
            denom = 0;
            chosen_util = 0;
            total = 0;
            sat_seen = 0;
            coef_ovf = 0;
            errors = 0;
            sets_checked = 0;
        endfunction

        function longint unsigned root(longint unsigned v_in);
            longint unsigned v;
            longint unsigned r;
            longint unsigned b;
            v = v_in;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint clamp(longint v, longint lo, longint hi, inout bit ovf);
            if (v > hi) begin
                ovf = 1;
                return hi;
            end
            if (v < lo) begin
                ovf = 1;
                return lo;
            end
            return v;
        endfunction

        // Exponential of a Q16.16 value into unsigned Q16, clipped at limit
        function longint unsigned exp_q16(longint x, longint unsigned limit,
                                          inout bit ovf);
            longint          y;
            longint          k;
            longint          sh;
            longint unsigned f;
            longint unsigned acc;
            longint unsigned v;
            y = x * LOG2E;
            k = y >>> 46;
            f = (y >> 30) & 64'hFFFF;
            acc = 64'd1 << 30;
            for (int j = 0; j < 16; j++) begin
                if ((f >> (15 - j)) & 1) acc = (acc * pow2_frac[j] + (64'd1 << 29)) >> 30;
            end
            sh = k - 14;
            if (sh >= 0) begin
                if (sh > 17) begin
                    ovf = 1;
                    return limit;
                end
                v = acc << sh;
            end else begin
                if (-sh >= 62) return 0;
                v = (acc + (64'd1 << (-sh - 1))) >> (-sh);
            end
            if (v > limit) begin
                ovf = 1;
                return limit;
            end
            return v;
        endfunction

        // Natural logarithm of an unsigned Q32.16 value into Q16.16
        function longint ln_q16(longint unsigned d_in);
            longint unsigned d;
            longint unsigned m;
            longint          frac;
            longint          l2;
            int              p;
            d = d_in & UMAX48;
            if (d == 0) d = 1;
            p = 47;
            while (((d >> p) & 1) == 0) p--;
            m = (p >= 30) ? (d >> (p - 30)) : (d << (30 - p));
            frac = 0;
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    m = m >> 1;
                    frac = frac | 1;
                end
            end
            l2 = longint'(p - 16) * 65536 + frac;
            return (l2 * LN2 + (64'sd1 << 29)) >>> 30;
        endfunction

        // Register write; indexes outside the map are ignored
        function void write_reg(logic [2:0] idx, logic [31:0] data);
            bit any_ovf;
            bit one;
            longint unsigned e;
            if (idx < CFG_IDX_SIGN) raw_coef[idx] = longint'($signed(data));
            else if (idx == CFG_IDX_SIGN) sign_mode = data[11:0];
            else return;
            any_ovf = 0;
            for (int i = 0; i < 6; i++) begin
                one = 0;
                if (sign_mode[2*i +: 2] == SGN_POS || sign_mode[2*i +: 2] == SGN_NEG) begin
                    e = exp_q16(raw_coef[i], MAX32, one);
                    eff_coef[i] = (sign_mode[2*i +: 2] == SGN_POS) ? longint'(e) : -longint'(e);
                end else begin
                    eff_coef[i] = raw_coef[i];
                end
                if (one) any_ovf = 1;
            end
            coef_ovf = any_ovf;
        endfunction

        // Accepted row: update the set state, queue a result at a set end
        function void note_row(t_in_item r);
            longint          feat [6];
            longint          hi;
            longint          p;
            longint          util;
            longint          term;
            longint unsigned lo;
            longint unsigned e;
            t_out_item       res;
            feat[0] = longint'(r.feat_0);
            feat[1] = longint'(r.feat_1);
            feat[2] = longint'(r.feat_2);
            feat[3] = longint'(r.feat_3);
            feat[4] = longint'(r.feat_4);
            feat[5] = longint'(r.feat_5);
            if (r.data_start) begin
                total = 0;
                sat_seen = 0;
                denom = 0;
                chosen_util = 0;
            end
            hi = 0;
            lo = 0;
            for (int i = 0; i < 6; i++) begin
                p = eff_coef[i] * feat[i];
                hi += p >>> 16;
                lo += p & 64'hFFFF;
            end
            util = clamp(hi + longint'(lo >> 16), MIN32, MAX32, sat_seen);
            e = exp_q16(util, UMAX48, sat_seen);
            denom += e;
            if (denom > UMAX48) begin
                denom = UMAX48;
                sat_seen = 1;
            end
            if (r.is_chosen) chosen_util = util;
            if (!r.set_end) return;
            term = clamp(chosen_util - ln_q16(denom), MIN32, MAX32, sat_seen);
            total = clamp(total + term, MIN48, MAX48, sat_seen);
            res.occasion_term = term[31:0];
            res.running_total = total[47:0];
            res.saturated = sat_seen | coef_ovf;
            expected_sets = {expected_sets, res};
            denom = 0;
            chosen_util = 0;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            errors++;
            $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_sets.size() == 0) begin
                report_mismatch("unexpected result, term", longint'(got.occasion_term),
                                longint'(0));
                return;
            end
            want = expected_sets.pop_front();
            sets_checked++;
            if (got.occasion_term !== want.occasion_term)
                report_mismatch("occasion_term", longint'(got.occasion_term),
                                longint'(want.occasion_term));
            if (got.running_total !== want.running_total)
                report_mismatch("running_total", longint'(got.running_total),
                                longint'(want.running_total));
            if (got.saturated !== want.saturated)
                report_mismatch("saturated", longint'(got.saturated),
                                longint'(want.saturated));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    likelihood_scoreboard sb;
    bit calm;
    int rows_sent;

    mnl_log_likelihood_accumulator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("Timeout: the run did not finish");
        $display("Test completed with failures");
        $finish;
    end

    // Result side stalls in random bursts until the quiet part of the run
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 13);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    // Send one row and wait for its transaction, with an occasional gap before it
    task automatic send_row(t_in_item r);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_row(r);
        rows_sent++;
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        i_in_valid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every set result is in, then let trailing rows drain
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_sets.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_feat(int style);
        case (style)
            0: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            1: return $urandom();
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic t_in_item make_row(int style, bit chosen, bit last, bit first);
        t_in_item r;
        r.feat_0 = rand_feat(style);
        r.feat_1 = rand_feat(style);
        r.feat_2 = rand_feat(style);
        r.feat_3 = rand_feat(style);
        r.feat_4 = rand_feat(style);
        r.feat_5 = rand_feat(style);
        r.is_chosen = chosen;
        r.set_end = last;
        r.data_start = first;
        return r;
    endfunction

    // One choice set; occasionally with no choice, several choices or a restart
    task automatic send_set(bit first);
        int n;
        int pick;
        int style;
        int oddity;
        n = $urandom_range(1, 6);
        pick = $urandom_range(0, n - 1);
        oddity = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) begin
            style = ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 2);
            send_row(make_row(style,
                (oddity == 0) ? 1'b0 : (oddity == 1) ? 1'($urandom) : 1'(i == pick),
                (oddity == 2 && i == n - 1) ? 1'b0 : 1'(i == n - 1),
                (oddity == 3) ? 1'($urandom_range(0, 3) == 0) : 1'(first && i == 0)));
        end
    endtask

    function automatic logic [31:0] rand_coef(int style);
        case (style)
            0: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
            1: return 32'($signed($urandom_range(0, 10 << 16)) - (8 << 16));
            default: return $urandom();
        endcase
    endfunction

    task automatic configure(int style);
        logic [11:0] modes;
        for (int i = 0; i < 6; i++) write_cfg(3'(i), rand_coef(style));
        modes = 12'($urandom);
        if (style == 0) modes = 12'h000;
        write_cfg(CFG_IDX_SIGN, {20'($urandom), modes});
        if ($urandom_range(0, 1)) write_cfg(CFG_IDX_UNUSED, $urandom());
    endtask

    initial begin
        t_in_item r;
        sb = new();
        calm = 1'b0;
        rows_sent = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients: every utility is zero
        send_row(make_row(2, 1'b1, 1'b1, 1'b1));
        send_row(make_row(1, 1'b0, 1'b0, 1'b0));
        send_row(make_row(1, 1'b0, 1'b1, 1'b0));
        drain();

        // Moderate free coefficients with extreme features: utility overflow
        for (int i = 0; i < 6; i++) write_cfg(3'(i), 32'h0001_0000);
        write_cfg(CFG_IDX_SIGN, 32'({6{SGN_FREE}}));
        send_row(make_row(2, 1'b1, 1'b0, 1'b1));
        send_row(make_row(2, 1'b1, 1'b1, 1'b0));
        r = '0;
        r.feat_0 = 32'sh0020_0000;
        r.set_end = 1'b1;
        send_row(r);
        // Strongly negative utility: the denominator underflows to zero
        r.feat_0 = 32'h8000_0000;
        r.is_chosen = 1'b1;
        send_row(r);
        // Restart in the middle of a set discards the partial set
        send_row(make_row(0, 1'b1, 1'b0, 1'b0));
        send_row(make_row(0, 1'b0, 1'b1, 1'b1));
        drain();

        // Exponentiated coefficients at both extremes, code three treated as free
        for (int i = 0; i < 6; i++) write_cfg(3'(i), (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
        write_cfg(CFG_IDX_SIGN,
                  32'({SGN_POS, SGN_NEG, SGN_SPARE, SGN_FREE, SGN_NEG, SGN_POS}));
        write_cfg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
        send_row(make_row(0, 1'b1, 1'b1, 1'b1));
        send_row(make_row(2, 1'b1, 1'b1, 1'b0));
        send_row(make_row(1, 1'b0, 1'b1, 1'b0));
        drain();
        write_cfg(3'd0, 32'h0000_0000);
        write_cfg(CFG_IDX_SIGN, 32'({6{SGN_NEG}}));
        send_row(make_row(0, 1'b1, 1'b1, 1'b1));
        drain();

        // Random phases, the last without idling
        for (int ph = 0; ph < 6; ph++) begin
            configure(ph % 3);
            if (ph == 5) calm = 1'b1;
            for (int k = 0; k < 43; k++) begin
                send_set(k == 0 || $urandom_range(0, 15) == 0);
            end
            drain();
        end

        $display("Sent %0d rows and checked %0d set results over several coefficient settings",
                 rows_sent, sb.sets_checked);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
